// ===== hw/rtl/bffa_pkg.sv =====
// Shared types, codes and the popcount helper function of the first-fit bitmap allocator.
package bffa_pkg;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_FULL  = 3'd2,
        ST_FRAG  = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RANGE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [0:0] req_type;
        logic [7:0] unit_count;
        logic [6:0] base_index;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [6:0] alloc_base;
        logic [7:0] units_free;
    } t_rsp;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + {3'b000, v[i]};
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/bffa_map_ram.sv =====
// Occupancy bitmap memory with a registered read port and per-entry valid flags.
module bffa_map_ram
    import bffa_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_vld  <= r_vld[i_rd_addr];
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'h00;

endmodule

// ===== hw/rtl/bffa_byte_scan.sv =====
// Run tracker that advances the first-fit search across one bitmap byte.
module bffa_byte_scan
    import bffa_pkg::*;
#(
    parameter int NUM_UNITS = 128,
    parameter int AW        = 4,
    parameter int IW        = 7
) (
    input  logic [AW-1:0] i_byte,
    input  logic [7:0]    i_data,
    input  logic [7:0]    i_run,
    input  logic [IW-1:0] i_start,
    input  logic [7:0]    i_count,
    output logic          o_hit,
    output logic [7:0]    o_run,
    output logic [IW-1:0] o_start
);

    localparam logic [IW:0] LIMIT = (IW+1)'(NUM_UNITS);

    always_comb begin
        logic [IW-1:0] unit;
        logic [7:0]    run;
        logic [IW-1:0] start;
        logic          hit;
        run   = i_run;
        start = i_start;
        hit   = 1'b0;
        for (int i = 0; i < 8; i++) begin
            unit = {i_byte, 3'(i)};
            if (!hit) begin
                if (i_data[i] || ({1'b0, unit} >= LIMIT)) begin
                    run = '0;
                end else begin
                    if (run == 8'd0) begin
                        start = unit;
                    end
                    run = run + 8'd1;
                    if (run == i_count) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        o_hit   = hit;
        o_run   = run;
        o_start = start;
    end

endmodule

// ===== hw/rtl/bitmap_first_fit_allocator.sv =====
// A rejected or empty request goes straight to its result; an allocate scans bitmap bytes
// for a free run, then rewrites the bytes it covers; a free rewrites only its range's bytes.
// Scan reads one byte per cycle, rewrite reads and writes one, through the single map memory.
// The block is ready for the next request as soon as the result enters the output register.
// Reset clears the control state, the free count and the memory's valid flags at once,
// so the bitmap reads as all free with no clearing pass.
module bitmap_first_fit_allocator
    import bffa_pkg::*;
#(
    parameter int NUM_UNITS = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int MB = (NUM_UNITS + 7) / 8;
    localparam int AW = (MB > 1) ? $clog2(MB) : 1;
    localparam int IW = AW + 3;
    localparam int CW = $clog2(NUM_UNITS + 1);
    localparam int SW = (CW > 9) ? CW : 9;
    localparam logic [AW-1:0] LAST_BYTE = AW'(MB - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_byte, n_byte;
    logic [7:0]    r_run, n_run;
    logic [7:0]    r_count, n_count;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic          r_set, n_set;
    logic [CW-1:0] r_free, n_free;
    t_status       r_status, n_status;
    logic [6:0]    r_base, n_base;
    logic          r_out_vld, n_out_vld;
    t_rsp          r_out, n_out;

    logic          wr_en;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          scan_hit;
    logic [7:0]    scan_run;
    logic [IW-1:0] scan_start;
    logic [SW-1:0] base_ext;
    logic [SW-1:0] range_end;
    logic [SW-1:0] free_last;
    logic [7:0]    mask;

    bffa_map_ram #(
        .DEPTH (MB),
        .AW    (AW)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_byte),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bffa_byte_scan #(
        .NUM_UNITS (NUM_UNITS),
        .AW        (AW),
        .IW        (IW)
    ) u_scan (
        .i_byte  (r_byte),
        .i_data  (rd_data),
        .i_run   (r_run),
        .i_start (r_lo),
        .i_count (r_count),
        .o_hit   (scan_hit),
        .o_run   (scan_run),
        .o_start (scan_start)
    );

    assign base_ext  = SW'(i_req.base_index);
    assign range_end = base_ext + SW'(i_req.unit_count);
    assign free_last = range_end - SW'(1);

    always_comb begin
        logic [IW-1:0] unit;
        for (int i = 0; i < 8; i++) begin
            unit    = {r_byte, 3'(i)};
            mask[i] = (unit >= r_lo) && (unit <= r_hi);
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= CW'(NUM_UNITS);
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_run    <= n_run;
        r_count  <= n_count;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_set    <= n_set;
        r_status <= n_status;
        r_base   <= n_base;
        r_out    <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_byte    = r_byte;
        n_run     = r_run;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_set     = r_set;
        n_free    = r_free;
        n_status  = r_status;
        n_base    = r_base;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        wr_en     = 1'b0;
        wr_data   = rd_data;
        rd_addr   = r_byte + AW'(1);

        if (r_out_vld && i_rsp_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                rd_addr = (i_req.req_type == REQ_FREE) ? base_ext[IW-1:3] : '0;
                if (i_req_valid) begin
                    n_byte   = '0;
                    n_run    = '0;
                    n_lo     = '0;
                    n_base   = '0;
                    n_count  = i_req.unit_count;
                    n_status = ST_OK;
                    if (i_req.req_type == REQ_ALLOC) begin
                        n_set = 1'b1;
                        if (i_req.unit_count == 8'd0) begin
                            n_status = ST_ZERO;
                            n_state  = S_DONE;
                        end else if (SW'(i_req.unit_count) > SW'(r_free)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_set = 1'b0;
                        if (range_end > SW'(NUM_UNITS)) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else if (i_req.unit_count == 8'd0) begin
                            n_state = S_DONE;
                        end else begin
                            n_lo    = base_ext[IW-1:0];
                            n_hi    = free_last[IW-1:0];
                            n_byte  = base_ext[IW-1:3];
                            n_state = S_RANGE;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_run = scan_run;
                n_lo  = scan_start;
                if (scan_hit) begin
                    rd_addr = scan_start[IW-1:3];
                    n_hi    = scan_start + IW'(r_count) - IW'(1);
                    n_byte  = scan_start[IW-1:3];
                    n_free  = r_free - CW'(r_count);
                    n_base  = 7'(scan_start);
                    n_state = S_RANGE;
                end else if (r_byte == LAST_BYTE) begin
                    n_status = ST_FRAG;
                    n_state  = S_DONE;
                end else begin
                    n_byte = r_byte + AW'(1);
                end
            end
            S_RANGE: begin
                wr_en = 1'b1;
                if (r_set) begin
                    wr_data = rd_data | mask;
                end else begin
                    wr_data = rd_data & ~mask;
                    n_free  = r_free + CW'(popcount8(rd_data & mask));
                end
                if (r_byte == r_hi[IW-1:3]) begin
                    n_state = S_DONE;
                end else begin
                    n_byte = r_byte + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_rsp_ready) begin
                    n_out_vld        = 1'b1;
                    n_out.status     = r_status;
                    n_out.alloc_base = r_base;
                    n_out.units_free = 8'(r_free);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CW'(NUM_UNITS))
        else $error("free count exceeds the pool size");

    a_fail_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status != ST_OK)) |-> (r_out.alloc_base == 7'd0))
        else $error("failed request reports a nonzero base");

    a_range_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANGE) |-> ((r_byte >= r_lo[IW-1:3]) && (r_byte <= r_hi[IW-1:3])))
        else $error("bitmap write outside the requested range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state != S_IDLE))
        else $error("accepted beat did not start any work");
`endif

endmodule

// ===== tb/bitmap_first_fit_allocator_checker.sv =====
`timescale 1ns / 100ps
// Channel checker for the first-fit bitmap allocator: it predicts every response beat and compares.
module bitmap_first_fit_allocator_checker
    import bffa_pkg::*;
#(
    parameter int NUM_UNITS = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);

    logic [NUM_UNITS-1:0] unit_busy;
    int                   units_left;
    t_rsp                 expected_rsp_q[$];
    int                   mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic serve_request(input t_req r, output t_rsp rsp);
        int  count;
        int  run;
        int  start;
        bit  hit;
        rsp.status     = ST_OK;
        rsp.alloc_base = '0;
        count          = int'(r.unit_count);
        if (t_req_type'(r.req_type) == REQ_ALLOC) begin
            if (count == 0) begin
                rsp.status = ST_ZERO;
            end else if (count > units_left) begin
                rsp.status = ST_FULL;
            end else begin
                run   = 0;
                start = 0;
                hit   = 1'b0;
                for (int u = 0; u < NUM_UNITS && !hit; u++) begin
                    if (unit_busy[u]) begin
                        run = 0;
                    end else begin
                        if (run == 0) begin
                            start = u;
                        end
                        run++;
                        if (run == count) begin
                            hit = 1'b1;
                        end
                    end
                end
                if (hit) begin
                    for (int u = start; u < start + count; u++) begin
                        unit_busy[u] = 1'b1;
                    end
                    units_left     -= count;
                    rsp.alloc_base  = 7'(start);
                end else begin
                    rsp.status = ST_FRAG;
                end
            end
        end else if (int'(r.base_index) + count > NUM_UNITS) begin
            rsp.status = ST_RANGE;
        end else begin
            // Only units that were really in use add to the free count.
            for (int u = int'(r.base_index); u < int'(r.base_index) + count; u++) begin
                if (unit_busy[u]) begin
                    unit_busy[u] = 1'b0;
                    units_left++;
                end
            end
        end
        rsp.units_free = 8'(units_left);
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            unit_busy  = '0;
            units_left = NUM_UNITS;
            expected_rsp_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: response beat with none expected, actual status %0d",
                             $time, i_rsp.status);
                end else begin
                    want = expected_rsp_q.pop_front();
                    compare_field("status", int'(want.status), int'(i_rsp.status));
                    compare_field("alloc_base", int'(want.alloc_base), int'(i_rsp.alloc_base));
                    compare_field("units_free", int'(want.units_free), int'(i_rsp.units_free));
                end
            end
            if (i_req_valid && i_req_ready) begin
                serve_request(i_req, want);
                expected_rsp_q.push_back(want);
            end
            o_outstanding <= expected_rsp_q.size();
        end
    end

endmodule

// ===== tb/bitmap_first_fit_allocator_tb.sv =====
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request and response stimulus, and the verdict.
module bitmap_first_fit_allocator_tb;
    import bffa_pkg::*;

    localparam int NUM_UNITS    = 128;
    localparam int RANDOM_ITEMS = 1400;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        int base;
        int units;
    } t_block;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    int     fail_count;
    int     outstanding;
    int     idle_cycles = 0;
    bit     steady = 1'b0;
    int     sent_sizes[$];
    t_block live_blocks[$];

    always #5 i_clk = ~i_clk;

    bitmap_first_fit_allocator #(
        .NUM_UNITS(NUM_UNITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    bitmap_first_fit_allocator_checker #(
        .NUM_UNITS(NUM_UNITS)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    task automatic send_request(input t_req_type kind, input int count, input int base);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req <= '{req_type: kind, unit_count: 8'(count), base_index: 7'(base)};
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        sent_sizes.push_back(kind == REQ_ALLOC ? count : -1);
    endtask

    task automatic drain_responses();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Successful allocations are remembered so that most frees release real blocks.
    always @(posedge i_clk) begin
        int units;
        if (i_rst_n && o_rsp_valid && i_rsp_ready && sent_sizes.size() > 0) begin
            units = sent_sizes.pop_front();
            if (units > 0 && o_rsp.status == ST_OK) begin
                live_blocks.push_back('{int'(o_rsp.alloc_base), units});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("bitmap_first_fit_allocator regression: fail");
            $finish;
        end
    end

    initial begin
        int stall;
        i_rsp_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            do @(posedge i_clk); while (!o_rsp_valid);
        end
    end

    initial begin
        int     pick;
        int     size;
        int     base;
        int     idx;
        int     offset;
        t_block blk;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(REQ_ALLOC, 0, 85);
        send_request(REQ_ALLOC, 1, 127);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_FREE, 1, 127);
        send_request(REQ_ALLOC, 128, 0);
        send_request(REQ_FREE, 1, 0);
        send_request(REQ_ALLOC, 128, 42);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_FREE, 1, 127);
        send_request(REQ_FREE, 2, 127);
        send_request(REQ_FREE, 127, 1);
        send_request(REQ_FREE, 128, 0);
        send_request(REQ_ALLOC, 64, 0);
        send_request(REQ_ALLOC, 64, 0);
        send_request(REQ_FREE, 32, 32);
        send_request(REQ_FREE, 16, 96);
        send_request(REQ_ALLOC, 40, 0);
        send_request(REQ_ALLOC, 32, 0);
        send_request(REQ_ALLOC, 16, 0);
        send_request(REQ_ALLOC, 127, 0);
        send_request(REQ_FREE, 128, 0);
        send_request(REQ_ALLOC, 127, 0);
        send_request(REQ_FREE, 128, 1);
        send_request(REQ_FREE, 128, 0);
        drain_responses();
        live_blocks.delete();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            if (n % 350 == 349) begin
                drain_responses();
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    size = 0;
                end else if (pick < 70) begin
                    size = $urandom_range(1, 8);
                end else if (pick < 90) begin
                    size = $urandom_range(9, 32);
                end else if (pick < 98) begin
                    size = $urandom_range(33, 127);
                end else begin
                    size = 128;
                end
                send_request(REQ_ALLOC, size, $urandom_range(0, 127));
            end else if (pick < 80 && live_blocks.size() > 0) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                blk = live_blocks[idx];
                live_blocks.delete(idx);
                if ($urandom_range(0, 4) == 0 && blk.units > 1) begin
                    offset = $urandom_range(0, blk.units - 1);
                    size   = $urandom_range(1, blk.units - offset);
                    send_request(REQ_FREE, size, blk.base + offset);
                end else begin
                    send_request(REQ_FREE, blk.units, blk.base);
                end
            end else if (pick < 97) begin
                base = $urandom_range(0, 127);
                size = $urandom_range(0, 1) ? $urandom_range(0, NUM_UNITS - base)
                                            : $urandom_range(0, 128);
                send_request(REQ_FREE, size, base);
            end else begin
                send_request(REQ_FREE, 128, 0);
                live_blocks.delete();
            end
        end

        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bitmap_first_fit_allocator regression: pass");
        end else begin
            $display("bitmap_first_fit_allocator regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bffa_pkg.sv
hw/rtl/bffa_map_ram.sv
hw/rtl/bffa_byte_scan.sv
hw/rtl/bitmap_first_fit_allocator.sv
tb/bitmap_first_fit_allocator_checker.sv
tb/bitmap_first_fit_allocator_tb.sv
